@@ src/i2cms_pkg.sv @@
// Package with the shared codes and the result record of the I2C transfer sequencer.
`default_nettype none
package i2cms_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_RESTART = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_RECV    = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_NACK = 2'd2;

    // One result record. When use_buf is set, the byte comes from the
    // write buffer read that was issued with the transaction.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_byte;
        logic       use_buf;
        logic       ack_off;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_pos;
        logic       done_res;
        logic [8:0] bytes_done;
        logic [1:0] status;
    } res_t;

endpackage
`default_nettype wire

@@ src/i2cms_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ src/i2cms_ctrl.sv @@
// Transfer state registers and the per-transaction decision of the sequencer.
`default_nettype none
module i2cms_ctrl #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [1:0]                   kind,
    input  wire logic [6:0]                   dev_addr,
    input  wire logic [7:0]                   tx_count,
    input  wire logic [7:0]                   rx_count,
    input  wire logic                         bus_busy,
    input  wire logic                         nack,
    input  wire logic [7:0]                   rx_value,
    output i2cms_pkg::res_t                   res,
    output logic                              buf_re,
    output logic      [$clog2(BUF_DEPTH)-1:0] buf_raddr
);
    import i2cms_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_TX   = 2'd2,
        PH_RX   = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] write_pos_reg, write_pos_next;
    logic [7:0] read_pos_reg, read_pos_next;
    logic [7:0] write_total_reg, write_total_next;
    logic [7:0] read_total_reg, read_total_next;
    logic [6:0] target_addr_reg, target_addr_next;

    logic [7:0] wp_inc;
    logic [7:0] rd_pos;
    logic       rd_pos_ok;
    logic       want_buf;

    assign wp_inc = 8'(write_pos_reg + 8'd1);

    always_comb
    begin
        phase_next       = phase_reg;
        write_pos_next   = write_pos_reg;
        read_pos_next    = read_pos_reg;
        write_total_next = write_total_reg;
        read_total_next  = read_total_reg;
        target_addr_next = target_addr_reg;
        res              = '0;
        want_buf         = 1'b0;
        rd_pos           = write_pos_reg;

        unique case (kind)
            KIND_LOAD:
            begin
                // The buffer write itself is done next to the memory.
            end
            KIND_START:
            begin
                if (bus_busy || phase_reg != PH_IDLE)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_BUSY;
                end
                else
                begin
                    target_addr_next = dev_addr;
                    write_total_next = tx_count;
                    read_total_next  = rx_count;
                    write_pos_next   = 8'd0;
                    read_pos_next    = 8'd0;
                    phase_next       = PH_ADDR;
                    res.action       = ACT_START;
                    res.out_byte     = {dev_addr, (tx_count == 8'd0)};
                end
            end
            KIND_EVENT:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_ADDR:
                    begin
                        if (nack)
                        begin
                            res.action = ACT_STOP;
                            res.status = ST_NACK;
                            res.done_res = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (write_pos_reg < write_total_reg)
                        begin
                            phase_next = PH_TX;
                            res.action = ACT_WRITE;
                            want_buf   = 1'b1;
                            rd_pos     = write_pos_reg;
                        end
                        else if (read_pos_reg < read_total_reg)
                        begin
                            phase_next  = PH_RX;
                            res.action  = ACT_RECV;
                            res.ack_off = (read_total_reg == 8'd1);
                        end
                        else
                        begin
                            res.action   = ACT_STOP;
                            res.status   = ST_OK;
                            res.done_res = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                    PH_TX:
                    begin
                        if (nack)
                        begin
                            res.action   = ACT_STOP;
                            res.status   = ST_NACK;
                            res.done_res = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            write_pos_next = wp_inc;
                            if (wp_inc >= write_total_reg)
                            begin
                                if (read_total_reg != 8'd0)
                                begin
                                    phase_next   = PH_ADDR;
                                    res.action   = ACT_RESTART;
                                    res.out_byte = {target_addr_reg, 1'b1};
                                end
                                else
                                begin
                                    res.action   = ACT_STOP;
                                    res.status   = ST_OK;
                                    res.done_res = 1'b1;
                                    phase_next   = PH_IDLE;
                                end
                            end
                            else
                            begin
                                res.action = ACT_WRITE;
                                want_buf   = 1'b1;
                                rd_pos     = wp_inc;
                            end
                        end
                    end
                    PH_RX:
                    begin
                        res.rx_valid  = 1'b1;
                        res.rx_byte   = rx_value;
                        res.rx_pos    = read_pos_reg;
                        read_pos_next = 8'(read_pos_reg + 8'd1);
                        if ({1'b0, read_total_reg} == 9'(read_pos_reg) + 9'd2)
                        begin
                            res.ack_off = 1'b1;
                        end
                        else if ({1'b0, read_total_reg} <= 9'(read_pos_reg) + 9'd1)
                        begin
                            res.action   = ACT_STOP;
                            res.status   = ST_OK;
                            res.done_res = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (res.done_res && phase_next == PH_IDLE && res.status != ST_BUSY)
        begin
            res.bytes_done = 9'(write_pos_next) + 9'(read_pos_next);
        end

        // A position past the end of the buffer sends a zero byte.
        rd_pos_ok   = {1'b0, rd_pos} < 9'(BUF_DEPTH);
        res.use_buf = want_buf && rd_pos_ok;
    end

    assign buf_re    = accept && res.use_buf;
    assign buf_raddr = rd_pos[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            write_pos_reg   <= 8'd0;
            read_pos_reg    <= 8'd0;
            write_total_reg <= 8'd0;
            read_total_reg  <= 8'd0;
            target_addr_reg <= 7'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            write_pos_reg   <= write_pos_next;
            read_pos_reg    <= read_pos_next;
            write_total_reg <= write_total_next;
            read_total_reg  <= read_total_next;
            target_addr_reg <= target_addr_next;
        end
    end

endmodule
`default_nettype wire

@@ src/i2c_master_transfer_sequencer.sv @@
// Top level of the I2C master write-then-read transfer sequencer.
// After its transaction is accepted, a result passes through the s1 register, which waits for
// the registered write buffer read, and then through the output register.
// Throughput: one transaction per cycle, sustained as long as results are taken.
// Reset clears the phase, positions, counts and address; buffer contents stay undefined.
`default_nettype none
module i2c_master_transfer_sequencer #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] kind,
    input  wire logic [6:0] dev_addr,
    input  wire logic [7:0] tx_count,
    input  wire logic [7:0] rx_count,
    input  wire logic [7:0] buf_index,
    input  wire logic [7:0] buf_value,
    input  wire logic       bus_busy,
    input  wire logic       nack,
    input  wire logic [7:0] rx_value,

    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [2:0]      action,
    output logic [7:0]      out_byte,
    output logic            ack_off,
    output logic            rx_valid,
    output logic [7:0]      rx_byte,
    output logic [7:0]      rx_pos,
    output logic            done_res,
    output logic [8:0]      bytes_done,
    output logic [1:0]      status
);
    import i2cms_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    // The pipeline has two registers: s1 holds the decision while the buffer
    // read completes, and the output register holds the finished result.
    // Because the transfer state is updated when a transaction is accepted,
    // the next transaction sees it at once and no interlock is needed.
    // A load writes the buffer at its accept edge; a later read of the same
    // entry is issued at a later edge and sees the new byte.

    logic            item_accept;
    logic            s1_advance;
    logic            s1_valid_reg, s1_valid_next;
    res_t            s1_res_reg;
    res_t            ctrl_res;
    res_t            out_reg;
    logic            result_valid_reg, result_valid_next;
    logic            buf_re;
    logic [AW-1:0]   buf_raddr;
    logic [7:0]      buf_rdata;
    logic            buf_we;

    // s1 moves on when the output register is empty or being emptied.
    assign s1_advance  = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && !s1_advance;
    assign item_accept = item_valid && !item_stall;

    assign buf_we = item_accept && (kind == KIND_LOAD) && ({1'b0, buf_index} < 9'(BUF_DEPTH));

    i2cms_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (item_accept),
        .kind       (kind),
        .dev_addr   (dev_addr),
        .tx_count   (tx_count),
        .rx_count   (rx_count),
        .bus_busy   (bus_busy),
        .nack       (nack),
        .rx_value   (rx_value),
        .res        (ctrl_res),
        .buf_re     (buf_re),
        .buf_raddr  (buf_raddr)
    );

    // The read port is enabled only at accept, so its data holds while s1 waits.
    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_index[AW-1:0]),
        .wdata (buf_value),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    always_comb
    begin
        s1_valid_next = item_accept || (s1_valid_reg && !s1_advance);
        if (s1_advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_res_reg <= ctrl_res;
        end
        if (s1_advance)
        begin
            out_reg <= s1_res_reg;
            if (s1_res_reg.use_buf)
            begin
                out_reg.out_byte <= buf_rdata;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign action       = out_reg.action;
    assign out_byte     = out_reg.out_byte;
    assign ack_off      = out_reg.ack_off;
    assign rx_valid     = out_reg.rx_valid;
    assign rx_byte      = out_reg.rx_byte;
    assign rx_pos       = out_reg.rx_pos;
    assign done_res     = out_reg.done_res;
    assign bytes_done   = out_reg.bytes_done;
    assign status       = out_reg.status;

endmodule
`default_nettype wire
